@@ rtl/clcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types, constants and the built-in font table of the lcd controller
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int DDRAM_DEPTH = 80;
   localparam int ADDR_W      = 7;

   // request kinds
   localparam logic [1:0] KIND_CMD   = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_BLINK = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [7:0]        data_byte;
      logic [ADDR_W-1:0] read_address;
   } item_type;

   // font for codes 0x20..0xff, five column bytes per code
   localparam logic [7:0] FONT_ROM [0:1119] = '{
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62, 8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h30,8'h30,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00, 8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14, 8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F, 8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
8'h15,8'h16,8'h7C,8'h16,8'h15, 8'h41,8'h41,8'h7F,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78, 8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,
8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78, 8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C, 8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h08,8'h2A,8'h1C,8'h08, 8'h08,8'h1C,8'h2A,8'h08,8'h08,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,
8'h00,8'h00,8'h00,8'h00,8'h00, 8'h70,8'h50,8'h70,8'h00,8'h00, 8'h00,8'h00,8'h0F,8'h01,8'h01, 8'h40,8'h40,8'h78,8'h00,8'h00,
8'h10,8'h20,8'h40,8'h00,8'h00, 8'h00,8'h18,8'h18,8'h00,8'h00, 8'h0A,8'h0A,8'h4A,8'h2A,8'h1E, 8'h04,8'h44,8'h34,8'h14,8'h0C,
8'h20,8'h10,8'h78,8'h04,8'h00, 8'h18,8'h08,8'h4C,8'h48,8'h38, 8'h48,8'h48,8'h78,8'h48,8'h48, 8'h48,8'h28,8'h18,8'h7C,8'h08,
8'h08,8'h7C,8'h08,8'h28,8'h18, 8'h40,8'h48,8'h48,8'h78,8'h40, 8'h54,8'h54,8'h54,8'h7C,8'h00, 8'h1C,8'h00,8'h5C,8'h40,8'h3C,
8'h08,8'h08,8'h08,8'h08,8'h08, 8'h01,8'h41,8'h3D,8'h09,8'h07, 8'h10,8'h08,8'h7C,8'h02,8'h01, 8'h0E,8'h02,8'h43,8'h22,8'h1E,
8'h42,8'h42,8'h7E,8'h42,8'h42, 8'h22,8'h12,8'h0A,8'h7F,8'h02, 8'h42,8'h3F,8'h02,8'h42,8'h3E, 8'h0A,8'h0A,8'h7F,8'h0A,8'h0A,
8'h08,8'h46,8'h42,8'h22,8'h1E, 8'h04,8'h03,8'h42,8'h3E,8'h02, 8'h42,8'h42,8'h42,8'h42,8'h7E, 8'h02,8'h4F,8'h22,8'h1F,8'h02,
8'h4A,8'h4A,8'h40,8'h20,8'h1C, 8'h42,8'h22,8'h12,8'h2A,8'h46, 8'h02,8'h3F,8'h42,8'h4A,8'h46, 8'h06,8'h48,8'h40,8'h20,8'h1E,
8'h08,8'h46,8'h4A,8'h32,8'h1E, 8'h0A,8'h4A,8'h3E,8'h09,8'h08, 8'h0E,8'h00,8'h4E,8'h20,8'h1E, 8'h04,8'h45,8'h3D,8'h05,8'h04,
8'h00,8'h7F,8'h08,8'h10,8'h00, 8'h44,8'h24,8'h1F,8'h04,8'h04, 8'h40,8'h42,8'h42,8'h42,8'h40, 8'h42,8'h2A,8'h12,8'h2A,8'h06,
8'h22,8'h12,8'h7B,8'h16,8'h22, 8'h00,8'h40,8'h20,8'h1F,8'h00, 8'h78,8'h00,8'h02,8'h04,8'h78, 8'h3F,8'h44,8'h44,8'h44,8'h44,
8'h02,8'h42,8'h42,8'h22,8'h1E, 8'h04,8'h02,8'h04,8'h08,8'h30, 8'h32,8'h02,8'h7F,8'h02,8'h32, 8'h02,8'h12,8'h22,8'h52,8'h0E,
8'h00,8'h2A,8'h2A,8'h2A,8'h40, 8'h38,8'h24,8'h22,8'h20,8'h70, 8'h40,8'h28,8'h10,8'h28,8'h06, 8'h0A,8'h3E,8'h4A,8'h4A,8'h4A,
8'h04,8'h7F,8'h04,8'h14,8'h0C, 8'h40,8'h42,8'h42,8'h7E,8'h40, 8'h4A,8'h4A,8'h4A,8'h4A,8'h7E, 8'h04,8'h05,8'h45,8'h25,8'h1C,
8'h0F,8'h40,8'h20,8'h1F,8'h00, 8'h7C,8'h00,8'h7E,8'h40,8'h30, 8'h7E,8'h40,8'h20,8'h10,8'h08, 8'h7E,8'h42,8'h42,8'h42,8'h7E,
8'h0E,8'h02,8'h42,8'h22,8'h1E, 8'h42,8'h42,8'h40,8'h20,8'h18, 8'h02,8'h04,8'h01,8'h02,8'h00, 8'h07,8'h05,8'h07,8'h00,8'h00,
8'h38,8'h44,8'h48,8'h30,8'h48, 8'h20,8'h55,8'h54,8'h55,8'h78, 8'hF8,8'h54,8'h54,8'h54,8'h28, 8'h28,8'h54,8'h54,8'h44,8'h20,
8'hFC,8'h20,8'h20,8'h10,8'h3C, 8'h38,8'h44,8'h4C,8'h54,8'h24, 8'hF0,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'hFC,
8'h20,8'h40,8'h3C,8'h04,8'h04, 8'h04,8'h04,8'h00,8'h0E,8'h00, 8'h00,8'h00,8'h04,8'hFD,8'h00, 8'h0A,8'h04,8'h0A,8'h00,8'h00,
8'h18,8'h24,8'h7E,8'h24,8'h10, 8'h14,8'h7F,8'h54,8'h40,8'h40, 8'h7C,8'h09,8'h05,8'h05,8'h78, 8'h38,8'h45,8'h44,8'h45,8'h38,
8'hFC,8'h28,8'h24,8'h24,8'h18, 8'h38,8'h44,8'h44,8'h48,8'hFC, 8'h3C,8'h4A,8'h4A,8'h4A,8'h3C, 8'h30,8'h28,8'h10,8'h28,8'h18,
8'h58,8'h64,8'h04,8'h64,8'h58, 8'h3C,8'h41,8'h40,8'h21,8'h7C, 8'h63,8'h55,8'h49,8'h41,8'h41, 8'h24,8'h1C,8'h04,8'h3C,8'h24,
8'h45,8'h29,8'h11,8'h29,8'h45, 8'h3C,8'h40,8'h40,8'h40,8'hFC, 8'h14,8'h14,8'h7C,8'h14,8'h12, 8'h44,8'h3C,8'h14,8'h14,8'h74,
8'h7C,8'h14,8'h1C,8'h14,8'h7C, 8'h10,8'h10,8'h54,8'h10,8'h10, 8'h00,8'h00,8'h00,8'h00,8'h00, 8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
   };

   // five font columns of a code at or above 0x20, column 0 in the low byte
   function automatic logic [39:0] font_columns(input logic [7:0] code);
      logic [10:0] base;
      logic [39:0] v;
      base = {3'b000, code - 8'h20} * 11'd5;
      for (int j = 0; j < 5; j++) begin
         v[8*j +: 8] = FONT_ROM[base + 11'(j)];
      end
      return v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/clcd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_front
// takes bus requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module clcd_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [1:0]                 req_opcode,
   input  wire  [7:0]                 req_data_byte,
   input  wire  [clcd_pkg::ADDR_W-1:0] req_read_address,
   input  wire                        pop,
   output clcd_pkg::item_type         head
);
   import clcd_pkg::*;

   item_type   entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic [1:0] kind;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      case (req_opcode)
         KIND_CMD:  kind = KIND_CMD;
         KIND_DATA: kind = KIND_DATA;
         KIND_READ: kind = KIND_READ;
         default:   kind = KIND_BLINK;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{valid: 1'b1, kind: kind, data_byte: req_data_byte,
                                  read_address: req_read_address};
      end
   end

   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      head.valid = (count_ff != 2'd0);
   end

endmodule
`default_nettype wire

@@ rtl/clcd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_back
// executes queued requests against the display and glyph stores
// ----------------------------------------------------------------------------
module clcd_back (
   input  wire                         clock,
   input  wire                         reset,
   input  clcd_pkg::item_type          head,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [39:0]                 rsp_glyph_columns,
   output logic [clcd_pkg::ADDR_W-1:0] rsp_cursor_address,
   output logic signed [6:0]           rsp_display_shift,
   output logic                        rsp_display_on,
   output logic                        rsp_cursor_on,
   output logic                        rsp_blink_phase,
   output logic                        rsp_cgram_selected,
   output logic                        rsp_eight_bit_mode,
   output logic                        rsp_changed
);
   import clcd_pkg::*;

   localparam logic ST_EXEC = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic [39:0] mem [0:DDRAM_DEPTH-1];
   logic [DDRAM_DEPTH-1:0] valid_ff;
   logic [39:0] glyph_ff [0:7];

   logic              state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [5:0]        gaddr_ff, gaddr_in;
   logic              gmode_ff, gmode_in;
   logic              dl_ff, dl_in, don_ff, don_in, con_ff, con_in, cbl_ff, cbl_in;
   logic              did_ff, did_in, dsh_ff, dsh_in;
   logic signed [6:0] shift_ff, shift_in;
   logic              pend_ff, pend_in;
   logic [3:0]        hold_ff, hold_in;
   logic [2:0]        bcnt_ff, bcnt_in;
   logic              bstate_ff, bstate_in;
   logic              changed_ff, changed_in;
   logic [ADDR_W-1:0] ra_ff, ra_in;

   logic              mem_we, glyph_we, clear;
   logic [39:0]       mem_wdata;
   logic              have, cmd_path, data_path;
   logic [7:0]        b;
   logic [ADDR_W-1:0] p;

   logic [39:0]       rd_data_ff;
   logic              rd_ok_ff;
   logic              strobe_ff;
   logic [ADDR_W-1:0] r_addr_ff;
   logic signed [6:0] r_shift_ff;
   logic              r_don_ff, r_con_ff, r_blink_ff, r_gmode_ff, r_dl_ff, r_changed_ff;

   function automatic logic signed [6:0] shift_up(input logic signed [6:0] s);
      logic signed [6:0] t;
      t = s + 7'sd1;
      if (t > 7'sd40) t = t - 7'sd40;
      return t;
   endfunction

   function automatic logic signed [6:0] shift_down(input logic signed [6:0] s);
      logic signed [6:0] t;
      t = s - 7'sd1;
      if (t < -7'sd40) t = t + 7'sd40;
      return t;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(DDRAM_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
      return (a == '0) ? ADDR_W'(DDRAM_DEPTH - 1) : a - 1'b1;
   endfunction

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      gaddr_in   = gaddr_ff;
      gmode_in   = gmode_ff;
      dl_in      = dl_ff;
      don_in     = don_ff;
      con_in     = con_ff;
      cbl_in     = cbl_ff;
      did_in     = did_ff;
      dsh_in     = dsh_ff;
      shift_in   = shift_ff;
      pend_in    = pend_ff;
      hold_in    = hold_ff;
      bcnt_in    = bcnt_ff;
      bstate_in  = bstate_ff;
      changed_in = changed_ff;
      ra_in      = ra_ff;
      pop        = 1'b0;
      mem_we     = 1'b0;
      glyph_we   = 1'b0;
      clear      = 1'b0;
      mem_wdata  = '0;
      have       = 1'b0;
      b          = 8'h00;
      p          = '0;
      cmd_path   = 1'b0;
      data_path  = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            if (head.valid) begin
               pop        = 1'b1;
               state_in   = ST_READ;
               ra_in      = head.read_address;
               changed_in = 1'b0;
               cmd_path   = (head.kind == KIND_CMD) || (head.kind == KIND_DATA && !don_ff);
               data_path  = (head.kind == KIND_DATA) && don_ff;
               // byte assembly, high nibble first on a 4-bit bus
               if (cmd_path || data_path) begin
                  if (dl_ff) begin
                     have = 1'b1;
                     b    = head.data_byte;
                  end else if (pend_ff) begin
                     have    = 1'b1;
                     pend_in = 1'b0;
                     b       = {hold_ff, head.data_byte[7:4]};
                  end else begin
                     pend_in = 1'b1;
                     hold_in = head.data_byte[7:4];
                  end
               end
               if (have && cmd_path) begin
                  if (b[7]) begin
                     p = (b[6:0] < 7'd40) ? b[6:0] : b[6:0] - 7'd24;
                     addr_in  = (p >= ADDR_W'(DDRAM_DEPTH)) ? '0 : p;
                     gmode_in = 1'b0;
                  end else if (b[6]) begin
                     gaddr_in = b[5:0];
                     gmode_in = 1'b1;
                  end else if (b[5]) begin
                     dl_in = b[4];
                  end else if (b[4]) begin
                     changed_in = 1'b1;
                     if (b[3]) shift_in = b[2] ? shift_up(shift_ff) : shift_down(shift_ff);
                     else      addr_in  = b[2] ? addr_inc(addr_ff) : addr_dec(addr_ff);
                  end else if (b[3]) begin
                     don_in     = b[2];
                     con_in     = b[1];
                     cbl_in     = b[0];
                     changed_in = 1'b1;
                  end else if (b[2]) begin
                     did_in = b[1];
                     dsh_in = b[0];
                  end else if (b[1]) begin
                     addr_in    = '0;
                     changed_in = 1'b1;
                  end else if (b[0]) begin
                     clear      = 1'b1;
                     addr_in    = '0;
                     shift_in   = '0;
                     did_in     = 1'b1;
                     changed_in = 1'b1;
                  end
               end
               if (have && data_path) begin
                  if (!gmode_ff) begin
                     mem_we     = 1'b1;
                     mem_wdata  = (b >= 8'h20) ? font_columns(b) : glyph_ff[b[2:0]];
                     changed_in = 1'b1;
                     if (did_ff) begin
                        addr_in = addr_inc(addr_ff);
                        if (dsh_ff) shift_in = shift_down(shift_ff);
                     end else begin
                        addr_in = addr_dec(addr_ff);
                        if (dsh_ff) shift_in = shift_up(shift_ff);
                     end
                  end else begin
                     glyph_we = 1'b1;
                     gaddr_in = gaddr_ff + 6'd1;
                  end
               end
               if (head.kind == KIND_BLINK) begin
                  if (con_ff && cbl_ff) begin
                     bcnt_in = bcnt_ff + 3'd1;
                     if (bcnt_in > 3'd4) begin
                        bcnt_in    = 3'd0;
                        bstate_in  = ~bstate_ff;
                        changed_in = 1'b1;
                     end
                  end else begin
                     bstate_in = 1'b0;
                  end
               end
            end
         end
         ST_READ: state_in = ST_EXEC;
         default: state_in = ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_EXEC;
         addr_ff    <= '0;
         gaddr_ff   <= '0;
         gmode_ff   <= 1'b0;
         dl_ff      <= 1'b0;
         don_ff     <= 1'b0;
         con_ff     <= 1'b0;
         cbl_ff     <= 1'b0;
         did_ff     <= 1'b0;
         dsh_ff     <= 1'b0;
         shift_ff   <= '0;
         pend_ff    <= 1'b0;
         hold_ff    <= '0;
         bcnt_ff    <= '0;
         bstate_ff  <= 1'b0;
         changed_ff <= 1'b0;
         ra_ff      <= '0;
         strobe_ff  <= 1'b0;
         valid_ff   <= '0;
         for (int e = 0; e < 8; e++) glyph_ff[e] <= '0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         gaddr_ff   <= gaddr_in;
         gmode_ff   <= gmode_in;
         dl_ff      <= dl_in;
         don_ff     <= don_in;
         con_ff     <= con_in;
         cbl_ff     <= cbl_in;
         did_ff     <= did_in;
         dsh_ff     <= dsh_in;
         shift_ff   <= shift_in;
         pend_ff    <= pend_in;
         hold_ff    <= hold_in;
         bcnt_ff    <= bcnt_in;
         bstate_ff  <= bstate_in;
         changed_ff <= changed_in;
         ra_ff      <= ra_in;
         strobe_ff  <= (state_ff == ST_READ);
         if (clear) valid_ff <= '0;
         else if (mem_we) valid_ff[addr_ff] <= 1'b1;
         // per-bit row write of one user glyph
         for (int e = 0; e < 8; e++) begin
            for (int j = 0; j < 5; j++) begin
               if (glyph_we && gaddr_ff[5:3] == 3'(e)) begin
                  glyph_ff[e][8*j + int'(gaddr_ff[2:0])] <= b[4-j];
               end
            end
         end
      end
   end

   // display store
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr_ff] <= mem_wdata;
      if (state_ff == ST_READ) rd_data_ff <= mem[ra_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_ok_ff     <= (ra_ff < ADDR_W'(DDRAM_DEPTH)) && valid_ff[ra_ff];
         r_addr_ff    <= addr_ff;
         r_shift_ff   <= shift_ff;
         r_don_ff     <= don_ff;
         r_con_ff     <= con_ff;
         r_blink_ff   <= bstate_ff;
         r_gmode_ff   <= gmode_ff;
         r_dl_ff      <= dl_ff;
         r_changed_ff <= changed_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_glyph_columns  = rd_ok_ff ? rd_data_ff : 40'd0;
   assign rsp_cursor_address = r_addr_ff;
   assign rsp_display_shift  = r_shift_ff;
   assign rsp_display_on     = r_don_ff;
   assign rsp_cursor_on      = r_con_ff;
   assign rsp_blink_phase    = r_blink_ff;
   assign rsp_cgram_selected = r_gmode_ff;
   assign rsp_eight_bit_mode = r_dl_ff;
   assign rsp_changed        = r_changed_ff;

`ifndef SYNTHESIS
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff < ADDR_W'(DDRAM_DEPTH)) else $error("address counter out of range");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      shift_ff <= 7'sd40 && shift_ff >= -7'sd40) else $error("shift out of range");
   a_blink_range: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= 3'd4) else $error("blink counter out of range");
   a_pop_read: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_READ && rsp_strobe == 1'b0) else $error("pop without read");
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back strobes");
`endif

endmodule
`default_nettype wire

@@ rtl/char_lcd_controller_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_controller_top
// character lcd controller: command/data bus front, executing back end
// ----------------------------------------------------------------------------
// path: a taken request passes the queue, the execute state and the store read
//   before its result shows, when the back end is free
// pacing: the back end takes no new request until the store read of the last
//   one is done; clear display clears all per-entry valid bits at once
// reset: synchronous; flags, counters, queue and store valid bits clear
//   at once, so the display store reads as zero; the receiver cannot stall
module char_lcd_controller_top (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [1:0]                  req_opcode,
   input  wire  [7:0]                  req_data_byte,
   input  wire  [clcd_pkg::ADDR_W-1:0] req_read_address,
   output logic                        rsp_strobe,
   output logic [39:0]                 rsp_glyph_columns,
   output logic [clcd_pkg::ADDR_W-1:0] rsp_cursor_address,
   output logic signed [6:0]           rsp_display_shift,
   output logic                        rsp_display_on,
   output logic                        rsp_cursor_on,
   output logic                        rsp_blink_phase,
   output logic                        rsp_cgram_selected,
   output logic                        rsp_eight_bit_mode,
   output logic                        rsp_changed
);
   import clcd_pkg::*;

   // queued request at the head and its pop
   item_type head;
   logic     pop;

   // front: takes a request whenever the queue has room
   clcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_read_address (req_read_address),
      .pop              (pop),
      .head             (head)
   );

   // back: executes one request, then reads the store for the result
   clcd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_glyph_columns  (rsp_glyph_columns),
      .rsp_cursor_address (rsp_cursor_address),
      .rsp_display_shift  (rsp_display_shift),
      .rsp_display_on     (rsp_display_on),
      .rsp_cursor_on      (rsp_cursor_on),
      .rsp_blink_phase    (rsp_blink_phase),
      .rsp_cgram_selected (rsp_cgram_selected),
      .rsp_eight_bit_mode (rsp_eight_bit_mode),
      .rsp_changed        (rsp_changed)
   );

endmodule
`default_nettype wire

@@ dv/clcd_checker.sv @@
// ----------------------------------------------------------------------------
// clcd_checker
// watches the request and result channels of the lcd controller, keeps its
// own copy of the controller state, predicts each result and compares
// ----------------------------------------------------------------------------
module clcd_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire                         busy,
   input  wire  [1:0]                  req_opcode,
   input  wire  [7:0]                  req_data_byte,
   input  wire  [clcd_pkg::ADDR_W-1:0] req_read_address,
   input  wire                         rsp_strobe,
   input  wire  [39:0]                 rsp_glyph_columns,
   input  wire  [clcd_pkg::ADDR_W-1:0] rsp_cursor_address,
   input  wire  signed [6:0]           rsp_display_shift,
   input  wire                         rsp_display_on,
   input  wire                         rsp_cursor_on,
   input  wire                         rsp_blink_phase,
   input  wire                         rsp_cgram_selected,
   input  wire                         rsp_eight_bit_mode,
   input  wire                         rsp_changed,
   output int                          fail_count,
   output int                          pending,
   output int                          result_count
);
   import clcd_pkg::*;

   typedef struct {
      logic [39:0]        columns;
      logic [ADDR_W-1:0]  cursor;
      logic signed [6:0]  shift;
      logic               disp_on;
      logic               cur_on;
      logic               phase;
      logic               cgram;
      logic               wide;
      logic               changed;
   } lcd_view_type;

   lcd_view_type screen_q[$];

   logic [39:0] char_ram [DDRAM_DEPTH];
   logic [39:0] user_glyph [8];
   int          addr_ctr;
   logic [5:0]  cg_addr;
   logic        in_cgram;
   logic        wide_bus, two_line, big_font, move_right, shift_sel;
   logic        disp_on, cur_on, cur_blink, step_up, track_shift;
   int          shift_pos;
   logic        half_waiting;
   logic [3:0]  half_held;
   logic [2:0]  blink_ctr;
   logic        blink_ph;

   task automatic clear_state();
      for (int i = 0; i < DDRAM_DEPTH; i++) char_ram[i] = '0;
      for (int i = 0; i < 8; i++) user_glyph[i] = '0;
      addr_ctr = 0; cg_addr = '0; in_cgram = 0;
      {wide_bus, two_line, big_font, move_right, shift_sel} = '0;
      {disp_on, cur_on, cur_blink, step_up, track_shift} = '0;
      shift_pos = 0; half_waiting = 0; half_held = '0;
      blink_ctr = '0; blink_ph = 0;
   endtask

   task automatic bump_shift(input bit up);
      if (up) begin
         shift_pos++;
         if (shift_pos > 40) shift_pos -= 40;
      end else begin
         shift_pos--;
         if (shift_pos < -40) shift_pos += 40;
      end
   endtask

   task automatic bump_addr(input bit up);
      if (up) addr_ctr = (addr_ctr + 1 >= DDRAM_DEPTH) ? 0 : addr_ctr + 1;
      else addr_ctr = (addr_ctr == 0) ? DDRAM_DEPTH - 1 : addr_ctr - 1;
   endtask

   // nibble pairing in 4-bit mode, high half first
   task automatic gather(input logic [7:0] raw, output bit ready, output logic [7:0] full);
      ready = 1;
      full = raw;
      if (!wide_bus) begin
         if (half_waiting) begin
            half_waiting = 0;
            full = {half_held, raw[7:4]};
         end else begin
            half_waiting = 1;
            half_held = raw[7:4];
            ready = 0;
         end
      end
   endtask

   task automatic do_instruction(input logic [7:0] raw, output bit chg);
      bit         ready;
      logic [7:0] b;
      int         p;
      chg = 0;
      gather(raw, ready, b);
      if (!ready) return;
      if (b[7]) begin
         p = b[6:0];
         addr_ctr = (p < 40) ? p : p - 24;
         if (addr_ctr >= DDRAM_DEPTH) addr_ctr = 0;
         in_cgram = 0;
      end else if (b[6]) begin
         cg_addr = b[5:0];
         in_cgram = 1;
      end else if (b[5]) begin
         wide_bus = b[4]; two_line = b[3]; big_font = b[2];
      end else if (b[4]) begin
         move_right = b[2]; shift_sel = b[3];
         if (b[3]) bump_shift(move_right);
         else bump_addr(move_right);
         chg = 1;
      end else if (b[3]) begin
         disp_on = b[2]; cur_on = b[1]; cur_blink = b[0];
         chg = 1;
      end else if (b[2]) begin
         step_up = b[1]; track_shift = b[0];
      end else if (b[1]) begin
         addr_ctr = 0;
         chg = 1;
      end else if (b[0]) begin
         for (int i = 0; i < DDRAM_DEPTH; i++) char_ram[i] = '0;
         addr_ctr = 0; shift_pos = 0; step_up = 1;
         chg = 1;
      end
   endtask

   task automatic do_char(input logic [7:0] raw, output bit chg);
      bit          ready;
      logic [7:0]  b;
      logic [39:0] cols;
      chg = 0;
      if (!disp_on) begin
         do_instruction(raw, chg);
         return;
      end
      gather(raw, ready, b);
      if (!ready) return;
      if (!in_cgram) begin
         if (b >= 8'h20) begin
            for (int j = 0; j < 5; j++) cols[8*j +: 8] = FONT_ROM[(int'(b) - 32) * 5 + j];
         end else begin
            cols = user_glyph[b[2:0]];
         end
         char_ram[addr_ctr] = cols;
         bump_addr(step_up);
         if (track_shift) bump_shift(!step_up);
         chg = 1;
      end else begin
         for (int j = 0; j < 5; j++) user_glyph[cg_addr[5:3]][8*j + cg_addr[2:0]] = b[4-j];
         cg_addr = cg_addr + 6'd1;
      end
   endtask

   task automatic predict_request(input logic [1:0] op, input logic [7:0] byte_in,
                                  input logic [ADDR_W-1:0] ra);
      lcd_view_type v;
      bit           chg;
      chg = 0;
      case (op)
         KIND_CMD:  do_instruction(byte_in, chg);
         KIND_DATA: do_char(byte_in, chg);
         KIND_BLINK: begin
            if (cur_on && cur_blink) begin
               blink_ctr = blink_ctr + 3'd1;
               if (blink_ctr > 3'd4) begin
                  blink_ctr = '0;
                  blink_ph = !blink_ph;
                  chg = 1;
               end
            end else begin
               blink_ph = 0;
            end
         end
         default: ;
      endcase
      v.columns = (ra < DDRAM_DEPTH) ? char_ram[ra] : '0;
      v.cursor  = ADDR_W'(addr_ctr);
      v.shift   = 7'(shift_pos);
      v.disp_on = disp_on;
      v.cur_on  = cur_on;
      v.phase   = blink_ph;
      v.cgram   = in_cgram;
      v.wide    = wide_bus;
      v.changed = chg;
      screen_q.push_back(v);
   endtask

   always @(posedge clock) begin
      lcd_view_type e;
      if (reset) begin
         clear_state();
         screen_q.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (screen_q.size() == 0) begin
               $error("result with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = screen_q.pop_front();
               if (rsp_glyph_columns !== e.columns)
                  $error("glyph_columns exp %h got %h", e.columns, rsp_glyph_columns);
               if (rsp_cursor_address !== e.cursor)
                  $error("cursor_address exp %0d got %0d", e.cursor, rsp_cursor_address);
               if (rsp_display_shift !== e.shift)
                  $error("display_shift exp %0d got %0d", e.shift, rsp_display_shift);
               if (rsp_display_on !== e.disp_on)
                  $error("display_on exp %b got %b", e.disp_on, rsp_display_on);
               if (rsp_cursor_on !== e.cur_on)
                  $error("cursor_on exp %b got %b", e.cur_on, rsp_cursor_on);
               if (rsp_blink_phase !== e.phase)
                  $error("blink_phase exp %b got %b", e.phase, rsp_blink_phase);
               if (rsp_cgram_selected !== e.cgram)
                  $error("cgram_selected exp %b got %b", e.cgram, rsp_cgram_selected);
               if (rsp_eight_bit_mode !== e.wide)
                  $error("eight_bit_mode exp %b got %b", e.wide, rsp_eight_bit_mode);
               if (rsp_changed !== e.changed)
                  $error("changed exp %b got %b", e.changed, rsp_changed);
               if (rsp_glyph_columns !== e.columns || rsp_cursor_address !== e.cursor ||
                   rsp_display_shift !== e.shift || rsp_display_on !== e.disp_on ||
                   rsp_cursor_on !== e.cur_on || rsp_blink_phase !== e.phase ||
                   rsp_cgram_selected !== e.cgram || rsp_eight_bit_mode !== e.wide ||
                   rsp_changed !== e.changed)
                  fail_count <= fail_count + 1;
            end
         end
         if (start && !busy) predict_request(req_opcode, req_data_byte, req_read_address);
      end
      pending = screen_q.size();
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// lcd controller regression: directed command set walk, then random bus
// traffic with random gaps; results are checked by clcd_checker
// ----------------------------------------------------------------------------
module tb_top;
   import clcd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 0;
   logic                reset = 1;
   logic                start = 0;
   logic [1:0]          req_opcode = KIND_READ;
   logic [7:0]          req_data_byte = '0;
   logic [ADDR_W-1:0]   req_read_address = '0;
   wire                 busy;
   wire                 rsp_strobe;
   wire  [39:0]         rsp_glyph_columns;
   wire  [ADDR_W-1:0]   rsp_cursor_address;
   wire  signed [6:0]   rsp_display_shift;
   wire                 rsp_display_on, rsp_cursor_on, rsp_blink_phase;
   wire                 rsp_cgram_selected, rsp_eight_bit_mode, rsp_changed;
   int                  fail_count, pending, result_count;
   int                  cycles = 0;
   int                  requests_sent = 0;

   always #5 clock = ~clock;

   char_lcd_controller_top dut (.*);

   clcd_checker u_checker (.*);

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("char_lcd_controller_top regression: fail");
         $finish;
      end
   end

   // one request: optional gap, then hold start until the block takes it
   // (called right after an edge; start stays high on back-to-back requests)
   task automatic send(input logic [1:0] op, input logic [7:0] b, input logic [6:0] ra,
                       input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_data_byte <= b;
      req_read_address <= ra;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   // sender holds off until every result is back, plus the latency
   task automatic drain();
      start <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   // a random instruction byte, weighted so clear stays rare
   function automatic logic [7:0] pick_instruction();
      int   k;
      logic [7:0] r;
      k = $urandom_range(0, 99);
      r = 8'($urandom);
      if (k < 20) return {1'b1, r[6:0]};               // set ddram address
      else if (k < 32) return {2'b01, r[5:0]};         // set cgram address
      else if (k < 40) return {3'b001, r[4:0]};        // function set
      else if (k < 60) return {4'b0001, r[3:0]};       // cursor or display shift
      else if (k < 75) return {5'b00001, r[2:0]};      // display control
      else if (k < 88) return {6'b000001, r[1:0]};     // entry mode
      else if (k < 94) return {7'b0000001, r[0]};      // home
      else if (k < 97) return 8'h01;                   // clear
      else return 8'h00;                               // null
   endfunction

   // a whole instruction; in 4-bit mode sent as two halves
   task automatic send_instruction(input logic [7:0] b, input bit wide);
      if (wide) send(KIND_CMD, b, 7'($urandom_range(0, 127)));
      else begin
         send(KIND_CMD, {b[7:4], 4'($urandom)}, 7'($urandom_range(0, 127)));
         send(KIND_CMD, {b[3:0], 4'($urandom)}, 7'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      int  k, n;
      bit  wide;
      logic [7:0] b;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset state, null command, 4-bit pairing, then 8-bit mode
      send(KIND_READ, 8'h00, 7'd0);
      send(KIND_READ, 8'hFF, 7'd127);                  // read beyond the store
      send(KIND_DATA, 8'h00, 7'd0);                    // display off: data acts as command
      send(KIND_CMD,  8'h00, 7'd0);                    // null instruction completes pair
      send(KIND_CMD,  8'h30, 7'd0);                    // first half of function set
      send(KIND_CMD,  8'h0F, 7'd0);                    // second half: 8-bit
      send(KIND_CMD,  8'h0F, 7'd0);                    // display, cursor, blink on
      send(KIND_CMD,  8'h07, 7'd0);                    // increment with shift
      send(KIND_DATA, 8'h41, 7'd0, 1);
      send(KIND_DATA, 8'hFF, 7'd0, 1);
      send(KIND_CMD,  8'h41, 7'd0);                    // cgram address 1
      send(KIND_DATA, 8'h1F, 7'd0);
      send(KIND_DATA, 8'h15, 7'd0);
      send(KIND_CMD,  8'hFF, 7'd0);                    // ddram address past range wraps to 0
      send(KIND_DATA, 8'h00, 7'd0);                    // user glyph 0
      send(KIND_CMD,  8'hE7, 7'd79);                   // second line address
      send(KIND_CMD,  8'h04, 7'd79);                   // decrement, no shift
      send(KIND_CMD,  8'h1C, 7'd79);                   // display right
      send(KIND_CMD,  8'h18, 7'd79);                   // display left
      send(KIND_CMD,  8'h10, 7'd79);                   // cursor left
      send(KIND_CMD,  8'h14, 7'd79);                   // cursor right
      for (k = 0; k < 6; k++) send(KIND_BLINK, 8'h00, 7'd1, k[0]);
      send(KIND_CMD,  8'h02, 7'd1);                    // home
      send(KIND_CMD,  8'h01, 7'd1);                    // clear
      drain();

      // random traffic, mostly well formed for the current bus width
      wide = 1;
      while (requests_sent < 1920) begin
         k = $urandom_range(0, 99);
         if (k < 35) begin
            b = 8'($urandom);
            if (wide) send(KIND_DATA, b, 7'($urandom_range(0, 127)), $urandom_range(0, 3) == 0);
            else begin
               send(KIND_DATA, b, 7'($urandom_range(0, 127)));
               send(KIND_DATA, {b[3:0], 4'($urandom)}, 7'($urandom_range(0, 127)));
            end
         end else if (k < 60) begin
            b = pick_instruction();
            send_instruction(b, wide);
            if (b[7:5] == 3'b001) wide = b[4];
         end else if (k < 72) begin
            send(KIND_READ, 8'($urandom), 7'($urandom_range(0, 127)), $urandom_range(0, 1));
         end else if (k < 88) begin
            send(KIND_BLINK, 8'($urandom), 7'($urandom_range(0, 127)), $urandom_range(0, 1));
         end else if (k < 92) begin
            // long run of one shift direction to hit the wrap at 40
            b = ($urandom_range(0, 1) != 0) ? 8'h1C : 8'h18;
            n = $urandom_range(40, 46);
            for (int i = 0; i < n; i++) send_instruction(b, wide);
         end else if (k < 94) begin
            send_instruction(8'h0F, wide);            // cursor and blink on
         end else if (k < 96) begin
            drain();
         end else begin
            // stray half or opcode noise that can break pairing
            send(2'($urandom), 8'($urandom), 7'($urandom_range(0, 127)));
            if (!wide) send(KIND_CMD, 8'h20, 7'd0);   // resync attempt
         end
      end

      // wait out everything still in flight
      drain();
      $display("covered %0d requests and %0d results: all instructions, both bus widths,",
               requests_sent, result_count);
      $display("font and user glyph writes, shift and address wrap, blink ticks");
      if (fail_count == 0 && pending == 0)
         $display("char_lcd_controller_top regression: pass");
      else
         $display("char_lcd_controller_top regression: fail");
      $finish;
   end

endmodule
